@@ rtl/incremental_abs_central_moment_macros.svh @@
// Assertion macros for the incremental absolute central moment block.
// No dependencies.
`ifndef INCREMENTAL_ABS_CENTRAL_MOMENT_MACROS_SVH
`define INCREMENTAL_ABS_CENTRAL_MOMENT_MACROS_SVH
// implication checked on every clock unless reset
`define IACM_ASSERT_IMP(lbl, clk, rst_n, a, c, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) else $error(msg);
// next-cycle implication
`define IACM_ASSERT_NXT(lbl, clk, rst_n, a, c, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) else $error(msg);
`endif

@@ rtl/iacm_pkg.sv @@
// Package for the incremental absolute central moment block.
// Types and fixed constants; no dependencies.
package iacm_pkg;
    localparam int unsigned MOMENT_ORDER_W = 4;
    localparam logic [MOMENT_ORDER_W-1:0] MOMENT_ORDER_RST = 4'd2;
    localparam int unsigned SUM_OUT_W = 32;
    localparam int unsigned MEAN_OUT_W = 16;
    localparam logic [0:0] REG_MOMENT_ORDER = 1'b0;

    typedef struct packed {
        logic div_start;
        logic acc_start;
        logic load_out;
        logic refuse;
    } t_cmd;

    typedef struct packed {
        logic div_done;
        logic acc_done;
        logic full;
    } t_sts;
endpackage

@@ rtl/iacm_if.sv @@
// Valid/ready channel interface.
// Depends on nothing; payload width set by parameter.
interface iacm_if #(parameter int unsigned W = 17);
    logic         valid;
    logic         ready;
    logic [W-1:0] data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

@@ rtl/iacm_ram.sv @@
// Generic single-port-write, single-read RAM with registered read.
// No dependencies.
module iacm_ram #(
    parameter int unsigned WIDTH = 16,
    parameter int unsigned DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;
    always_ff @(posedge i_clk) begin
        if (i_we) r_mem[i_waddr] <= i_wdata;
        r_rdata <= r_mem[i_raddr];
    end
    assign o_rdata = r_rdata;
endmodule

@@ rtl/iacm_datapath.sv @@
// Datapath: sample store, mean divider, power chain and accumulator.
// Depends on iacm_pkg and iacm_ram.
module iacm_datapath import iacm_pkg::*; #(
    parameter int unsigned MAX_SAMPLES = 4096,
    parameter int unsigned SAMPLE_BITS = 16
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  t_cmd                      i_cmd,
    output t_sts                      o_sts,
    input  logic [SAMPLE_BITS-1:0]    i_x,
    input  logic                      i_start_new,
    input  logic [MOMENT_ORDER_W-1:0] i_order,
    output logic [SUM_OUT_W-1:0]      o_sum,
    output logic [MEAN_OUT_W-1:0]     o_mean,
    output logic                      o_refused
);
    localparam int unsigned AW = $clog2(MAX_SAMPLES);
    localparam int unsigned CW = $clog2(MAX_SAMPLES + 1);
    localparam int unsigned NW = SAMPLE_BITS + CW;
    localparam int unsigned DCW = $clog2(NW + 1);
    localparam int unsigned SW = SAMPLE_BITS + CW + 1;
    localparam logic [CW-1:0] MAXC = CW'(MAX_SAMPLES);

    logic [CW-1:0]          r_count;
    logic [SAMPLE_BITS-1:0] r_mean;
    logic [CW-1:0]          w_cnt0;
    // divider
    logic [NW-1:0]  r_num;
    logic [NW:0]    r_rem;
    logic [CW:0]    r_den;
    logic [NW-1:0]  r_quo;
    logic [DCW-1:0] r_dstep;
    logic           r_dbusy;
    logic           r_ddone;
    // accumulator
    logic [CW-1:0]          r_idx;
    logic [CW-1:0]          r_tot;
    logic [1:0]             r_phase;
    logic [SAMPLE_BITS:0]   r_term;
    logic [SAMPLE_BITS-1:0] r_dev;
    logic [MOMENT_ORDER_W-1:0] r_k;
    logic [SW-1:0]          r_acc;
    logic                   r_abusy;
    logic                   r_adone;
    logic [SAMPLE_BITS-1:0] w_rd;
    logic [2*SAMPLE_BITS:0] w_prod;
    logic [SW-1:0]          w_q;
    logic [NW:0]            w_trial;

    assign w_cnt0 = i_start_new ? '0 : r_count;
    assign o_sts.full = (w_cnt0 >= MAXC);
    assign o_sts.div_done = r_ddone;
    assign o_sts.acc_done = r_adone;

    iacm_ram #(.WIDTH(SAMPLE_BITS), .DEPTH(MAX_SAMPLES)) u_ram (
        .i_clk(i_clk), .i_we(i_cmd.div_start), .i_waddr(w_cnt0[AW-1:0]),
        .i_wdata(i_x), .i_raddr(r_idx[AW-1:0]), .o_rdata(w_rd)
    );

    assign w_trial = {r_rem[NW-1:0], r_num[NW-1]} - {{(NW-CW){1'b0}}, r_den};
    assign w_prod = r_term * {1'b0, r_dev};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0; r_mean <= '0; r_dbusy <= 1'b0; r_ddone <= 1'b0;
            r_abusy <= 1'b0; r_adone <= 1'b0; r_phase <= '0;
        end else begin
            r_ddone <= 1'b0;
            r_adone <= 1'b0;
            if (i_cmd.div_start) begin
                r_num <= NW'(r_mean) * NW'(w_cnt0) + NW'(i_x);
                r_rem <= '0;
                r_den <= (CW+1)'(w_cnt0) + 1'b1;
                r_dstep <= '0;
                r_dbusy <= 1'b1;
                r_count <= w_cnt0 + 1'b1;
            end else if (r_dbusy) begin
                r_num <= {r_num[NW-2:0], 1'b0};
                if (!w_trial[NW]) begin
                    r_rem <= w_trial; r_quo <= {r_quo[NW-2:0], 1'b1};
                end else begin
                    r_rem <= {r_rem[NW-1:0], r_num[NW-1]};
                    r_quo <= {r_quo[NW-2:0], 1'b0};
                end
                r_dstep <= r_dstep + 1'b1;
                if (r_dstep == DCW'(NW - 1)) begin
                    r_dbusy <= 1'b0; r_ddone <= 1'b1;
                end
            end
            if (r_ddone) r_mean <= r_quo[SAMPLE_BITS-1:0];
            if (i_cmd.acc_start) begin
                r_idx <= '0; r_tot <= r_count; r_acc <= '0;
                r_abusy <= 1'b1; r_phase <= 2'd0;
            end else if (r_abusy) begin
                case (r_phase)
                    2'd0: r_phase <= 2'd1;
                    2'd1: begin
                        r_dev <= (w_rd >= r_mean) ? w_rd - r_mean : r_mean - w_rd;
                        r_term <= {1'b1, {SAMPLE_BITS{1'b0}}};
                        r_k <= '0;
                        r_phase <= 2'd2;
                    end
                    2'd2: begin
                        if (r_k == i_order) begin
                            r_acc <= r_acc + SW'(r_term);
                            r_idx <= r_idx + 1'b1;
                            r_phase <= 2'd0;
                            if (r_idx + 1'b1 == r_tot) begin
                                r_abusy <= 1'b0; r_adone <= 1'b1;
                            end
                        end else begin
                            r_term <= w_prod[2*SAMPLE_BITS:SAMPLE_BITS];
                            r_k <= r_k + 1'b1;
                        end
                    end
                    default: r_phase <= 2'd0;
                endcase
            end
        end
    end

    generate
        if (SAMPLE_BITS >= 16) begin : g_shr
            assign w_q = r_acc >> (SAMPLE_BITS - 16);
        end else begin : g_shl
            assign w_q = r_acc << (16 - SAMPLE_BITS);
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            o_refused <= 1'b0;
            o_mean <= MEAN_OUT_W'(r_mean);
            if (SW > SUM_OUT_W && (w_q >> SUM_OUT_W) != '0) o_sum <= '1;
            else o_sum <= SUM_OUT_W'(w_q);
        end else if (i_cmd.refuse) begin
            o_refused <= 1'b1;
            o_mean <= MEAN_OUT_W'(r_mean);
            o_sum <= '0;
        end
    end
endmodule

@@ rtl/iacm_ctrl.sv @@
// Controller FSM sequencing divide, accumulate and output.
// Depends on iacm_pkg.
module iacm_ctrl import iacm_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    output logic o_out_valid,
    input  logic i_out_ready,
    input  t_sts i_sts,
    output t_cmd o_cmd
);
    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_DIV  = 2'd1;
    localparam logic [1:0] S_ACC  = 2'd2;
    logic [1:0] r_state, n_state;
    logic       r_ov;
    logic       w_take;

    assign o_in_ready = (r_state == S_IDLE) && (!r_ov || i_out_ready);
    assign w_take = i_in_valid && o_in_ready;
    assign o_out_valid = r_ov;

    always_comb begin
        n_state = r_state;
        o_cmd = '0;
        case (r_state)
            S_IDLE: if (w_take) begin
                if (i_sts.full) o_cmd.refuse = 1'b1;
                else begin o_cmd.div_start = 1'b1; n_state = S_DIV; end
            end
            S_DIV: if (i_sts.div_done) begin
                o_cmd.acc_start = 1'b1; n_state = S_ACC;
            end
            S_ACC: if (i_sts.acc_done && (!r_ov || i_out_ready)) begin
                o_cmd.load_out = 1'b1; n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE; r_ov <= 1'b0;
        end else begin
            r_state <= n_state;
            if (o_cmd.load_out || o_cmd.refuse) r_ov <= 1'b1;
            else if (i_out_ready) r_ov <= 1'b0;
        end
    end
endmodule

@@ rtl/incremental_abs_central_moment.sv @@
// Incremental absolute central moment, top level.
// Operation: a taken sample first runs the serial mean divide, then a walk of
// the N stored samples raising each deviation to the power p; refusal skips both.
// Throughput: one item at a time, set by the serial walk of the sample RAM.
// Reset: synchronous active low; count and mean zero, order 2, RAM not cleared.
module incremental_abs_central_moment import iacm_pkg::*; #(
    parameter int unsigned MAX_SAMPLES = 4096,
    parameter int unsigned SAMPLE_BITS = 16
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    iacm_if.sink            s_in,
    iacm_if.source          m_out,
    input  logic            psel,
    input  logic            penable,
    input  logic            pwrite,
    input  logic [2:0]      paddr,
    input  logic [31:0]     pwdata,
    output logic [31:0]     prdata,
    output logic            pready
);
    logic [MOMENT_ORDER_W-1:0] r_order;
    t_cmd w_cmd;
    t_sts w_sts;
    logic [SUM_OUT_W-1:0]  w_sum;
    logic [MEAN_OUT_W-1:0] w_mean;
    logic                  w_ref;

    assign pready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_order <= MOMENT_ORDER_RST;
        else if (psel && penable && pwrite && paddr[2] == REG_MOMENT_ORDER)
            r_order <= pwdata[MOMENT_ORDER_W-1:0];
    end
    assign prdata = (paddr[2] == REG_MOMENT_ORDER) ? 32'(r_order) : '0;

    iacm_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in_valid(s_in.valid),
        .o_in_ready(s_in.ready), .o_out_valid(m_out.valid),
        .i_out_ready(m_out.ready), .i_sts(w_sts), .o_cmd(w_cmd)
    );

    iacm_datapath #(.MAX_SAMPLES(MAX_SAMPLES), .SAMPLE_BITS(SAMPLE_BITS)) u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(w_cmd), .o_sts(w_sts),
        .i_x(s_in.data[SAMPLE_BITS-1:0]), .i_start_new(s_in.data[SAMPLE_BITS]),
        .i_order(r_order), .o_sum(w_sum), .o_mean(w_mean), .o_refused(w_ref)
    );

    assign m_out.data = {w_ref, w_mean, w_sum};
endmodule

@@ rtl/iacm_checker.sv @@
// Port-level checker for the moment block, with bind.
// Depends on the macros header.
`include "incremental_abs_central_moment_macros.svh"
module iacm_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        i_in_ready,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [48:0] i_out_data
);
    logic w_refd;
    logic w_sum_zero;
    logic w_stall;
    assign w_refd = i_out_valid && i_out_data[48];
    assign w_sum_zero = (i_out_data[31:0] == 32'd0);
    assign w_stall = i_out_valid && !i_out_ready;
    `IACM_ASSERT_IMP(a_ref_zero, i_clk, i_rst_n, w_refd, w_sum_zero, "refused sum nonzero")
    `IACM_ASSERT_NXT(a_hold, i_clk, i_rst_n, w_stall, i_out_valid && $stable(i_out_data), "result not held")
    `IACM_ASSERT_IMP(a_no_take, i_clk, i_rst_n, w_stall, !i_in_ready, "input taken while stalled")
endmodule

bind incremental_abs_central_moment iacm_checker u_chk (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in_valid(s_in.valid), .i_in_ready(s_in.ready),
    .i_out_valid(m_out.valid), .i_out_ready(m_out.ready), .i_out_data(m_out.data)
);

@@ tb/incremental_abs_central_moment_checker.sv @@
// Checker for the incremental absolute central moment block: watches the sample,
// result and register ports, predicts each result and compares it.
// Depends on iacm_pkg and iacm_if.
module incremental_abs_central_moment_checker import iacm_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    iacm_if             in_ch,
    iacm_if             out_ch,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    input  logic        pready,
    output int          o_errors
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic [SUM_OUT_W-1:0]  moment_sum;
        logic [MEAN_OUT_W-1:0] mean_res;
        logic                  refused;
    } t_moment_res;

    logic [MOMENT_ORDER_W-1:0] order_q;
    logic [15:0]               samples_q[$];
    logic [15:0]               mean_q;
    t_moment_res               pending_q[$];

    function automatic t_moment_res predict_moment(logic [15:0] x, logic start);
        t_moment_res r;
        longint unsigned sum, term, d, m;
        if (start) samples_q.delete();
        if (samples_q.size() >= 4096) begin
            r.moment_sum = '0;
            r.mean_res = mean_q;
            r.refused = 1'b1;
            return r;
        end
        m = (longint'(mean_q) * samples_q.size() + x) / (samples_q.size() + 1);
        mean_q = m[15:0];
        samples_q.insert(samples_q.size(), x);
        sum = 0;
        foreach (samples_q[i]) begin
            d = samples_q[i] >= mean_q ? samples_q[i] - mean_q : mean_q - samples_q[i];
            term = 64'h1_0000;
            for (int k = 0; k < order_q; k++) term = (term * d) >> 16;
            sum += term;
        end
        r.moment_sum = sum > 64'hFFFF_FFFF ? 32'hFFFF_FFFF : sum[31:0];
        r.mean_res = mean_q;
        r.refused = 1'b0;
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_moment_res got, want;
        if (!i_rst_n) begin
            order_q <= MOMENT_ORDER_RST;
            mean_q = '0;
            samples_q.delete();
            pending_q.delete();
            o_errors <= 0;
        end else begin
            if (psel && penable && pwrite && pready && paddr == 3'd0)
                order_q <= pwdata[MOMENT_ORDER_W-1:0];
            if (in_ch.valid && in_ch.ready)
                pending_q.insert(pending_q.size(),
                    predict_moment(in_ch.data[15:0], in_ch.data[16]));
            if (out_ch.valid && out_ch.ready) begin
                {got.refused, got.mean_res, got.moment_sum} = out_ch.data;
                if (pending_q.size() == 0) begin
                    if (o_errors < 10) $display("unexpected result %h", out_ch.data);
                    o_errors <= o_errors + 1;
                end else begin
                    want = pending_q.pop_front();
                    if (got.moment_sum !== want.moment_sum
                            || got.mean_res !== want.mean_res
                            || got.refused !== want.refused) begin
                        if (o_errors < 10)
                            $display("mismatch: sum %h/%h mean %h/%h refused %b/%b",
                                want.moment_sum, got.moment_sum, want.mean_res,
                                got.mean_res, want.refused, got.refused);
                        o_errors <= o_errors + 1;
                    end
                end
            end
        end
    end
endmodule

@@ tb/incremental_abs_central_moment_test.sv @@
// Top of the incremental absolute central moment testbench: clock, reset,
// sample and register stimulus, watchdog and verdict. Depends on iacm_pkg,
// iacm_if, the block and incremental_abs_central_moment_checker.
module incremental_abs_central_moment_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int STALL_LIMIT = 40000;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    int          errors;
    int          sent = 0, received = 0, quiet_cycles = 0, set_size = 0;
    bit          calm = 1'b0;
    int          ready_burst = 0;

    iacm_if #(.W(17)) samp_ch ();
    iacm_if #(.W(49)) res_ch ();

    initial begin
        samp_ch.valid = 1'b0;
        samp_ch.data = '0;
        res_ch.ready = 1'b0;
    end

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    incremental_abs_central_moment DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .s_in(samp_ch.sink), .m_out(res_ch.source),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    incremental_abs_central_moment_checker u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .in_ch(samp_ch), .out_ch(res_ch),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .pready(pready), .o_errors(errors)
    );

    // result side backpressure in bursts
    always @(posedge i_clk) begin
        if (res_ch.valid && res_ch.ready) received <= received + 1;
        if (calm) begin
            res_ch.ready <= 1'b1;
        end else if (ready_burst > 0) begin
            ready_burst <= ready_burst - 1;
        end else begin
            res_ch.ready <= ~res_ch.ready;
            ready_burst <= $urandom_range(1, 19);
        end
    end

    always @(posedge i_clk) begin
        if ((samp_ch.valid && samp_ch.ready) || (res_ch.valid && res_ch.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    task automatic send_sample(logic [15:0] x, logic start);
        if (!calm && $urandom_range(0, 3) == 0) begin
            samp_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge i_clk);
        end
        samp_ch.valid <= 1'b1;
        samp_ch.data <= {start, x};
        @(posedge i_clk);
        while (!samp_ch.ready) @(posedge i_clk);
        sent++;
    endtask

    task automatic drain_results();
        samp_ch.valid <= 1'b0;
        while (received != sent) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic write_order(logic [31:0] v);
        drain_results();
        psel <= 1'b1; pwrite <= 1'b1; paddr <= 3'd0; pwdata <= v;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic random_samples(int n);
        logic st;
        repeat (n) begin
            st = ($urandom_range(0, 7) == 0) || set_size >= 40;
            set_size = st ? 1 : set_size + 1;
            send_sample(16'($urandom), st);
        end
    endtask

    initial begin
        logic [31:0] orders[6] = '{32'd0, 32'd1, 32'd9, 32'd15, 32'hFFFF_FFF3, 32'd5};
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        // default order, first sample without start flag
        send_sample(16'h1234, 1'b0);
        send_sample(16'hFFFF, 1'b0);
        send_sample(16'h0000, 1'b0);
        send_sample(16'h8000, 1'b0);
        send_sample(16'hFFFF, 1'b1);
        send_sample(16'hFFFF, 1'b0);
        send_sample(16'h0000, 1'b1);
        send_sample(16'hFFFF, 1'b0);
        drain_results();
        write_order(32'd15);
        send_sample(16'h0000, 1'b1);
        send_sample(16'hFFFF, 1'b0);
        send_sample(16'h0001, 1'b0);
        write_order(32'd0);
        send_sample(16'h5555, 1'b1);
        send_sample(16'hAAAA, 1'b0);
        send_sample(16'h7FFF, 1'b0);
        write_order(32'd9);
        send_sample(16'h0000, 1'b1);
        send_sample(16'hFFFF, 1'b0);
        send_sample(16'h0000, 1'b0);
        set_size = 3;
        foreach (orders[i]) begin
            write_order(orders[i]);
            random_samples(17);
        end
        write_order(32'd2);
        calm = 1'b1;
        random_samples(20);
        drain_results();
        repeat (200) @(posedge i_clk);
        if (errors == 0 && received == sent)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end
endmodule
